/* src/nlrb_pkg.sv */
// Shared types, codes and constants of the nibble lookup rectangle blitter.
// Used by the colour datapath, the table RAM wiring and the top level.
package nlrb_pkg;

    localparam int ADDR_W        = 22;
    localparam int BANK_SHIFT    = 17;
    localparam int LIM_W         = 6 + BANK_SHIFT;
    localparam int TABLE_ENTRIES = 32;
    localparam int TAB_HALF      = TABLE_ENTRIES / 2;
    localparam int TAB_AW        = $clog2(TAB_HALF);

    typedef enum logic [1:0] {
        REQ_TABLE = 2'd0,
        REQ_START = 2'd1,
        REQ_BYTE  = 2'd2
    } t_req;

    localparam logic [2:0] GFX_8BIT     = 3'd0;
    localparam logic [2:0] GFX_HYBRID12 = 3'd1;
    localparam logic [2:0] GFX_HYBRID16 = 3'd2;
    localparam logic [2:0] GFX_PURE16   = 3'd3;
    localparam logic [2:0] GFX_PURE12   = 3'd4;

    localparam logic [2:0] CFG_GFX_TYPE     = 3'd0;
    localparam logic [2:0] CFG_MODE_FLAGS_A = 3'd1;
    localparam logic [2:0] CFG_MODE_FLAGS_B = 3'd2;
    localparam logic [2:0] CFG_SCROLL_Y     = 3'd3;
    localparam logic [2:0] CFG_FLIP_SCREEN  = 3'd4;
    localparam logic [2:0] CFG_ROM_BANK     = 3'd5;
    localparam logic [2:0] CFG_ROM_BANKS    = 3'd6;

    localparam int MFA_DIRECT = 2;
    localparam int MFA_UPPER  = 4;
    localparam int MFA_ALT    = 5;
    localparam int MFB_DIRECT = 6;
    localparam int MFB_LOW    = 7;

    localparam logic [7:0]  TRANSP_8  = 8'hff;
    localparam logic [11:0] TRANSP_12 = 12'hfff;
    localparam logic [15:0] TRANSP_16 = 16'hfff0;

    localparam logic [1:0] BE_NONE = 2'b00;
    localparam logic [1:0] BE_LOW  = 2'b01;
    localparam logic [1:0] BE_HIGH = 2'b10;
    localparam logic [1:0] BE_BOTH = 2'b11;

    typedef struct packed {
        logic [2:0] gfx_type;
        logic [7:0] flags_a;
        logic [7:0] flags_b;
    } t_mode;

    typedef struct packed {
        logic [15:0] data0;
        logic [15:0] data1;
        logic [1:0]  be0;
        logic [1:0]  be1;
    } t_pix;

endpackage

/* src/nibble_lookup_rect_blitter_unit.sv */
// Top level of the nibble lookup rectangle blitter: request decode, position
// and source counters, colour table RAMs and the result pair register.
// Depends on nlrb_pkg, nlrb_ram and nlrb_colour.
//
//   channel   direction  handshake                 payload
//   request   in         i_valid / o_ready         i_req_type .. i_src_byte
//   result    out        o_valid / i_ready         o_vram_addr .. o_last
//   config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A source byte reads the colour table at the edge that accepts it and waits in
// the table read stage until the pair register is free. Its two pixel beats
// then leave one after the other on the single result port, and a new byte may
// enter the table read stage while they do. Table writes and blit starts give
// no result, but any request waits while a byte held in the table read stage
// cannot move on. Reset is synchronous and needs no clearing pass; a stalled
// result holds its pair register while one more byte waits in the read stage.
module nibble_lookup_rect_blitter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [4:0]  i_table_index,
    input  logic [7:0]  i_table_value,
    input  logic [7:0]  i_dest_x,
    input  logic [7:0]  i_dest_y,
    input  logic [7:0]  i_size_x,
    input  logic [7:0]  i_size_y,
    input  logic        i_dir_x,
    input  logic        i_dir_y,
    input  logic [15:0] i_source_start,
    input  logic [7:0]  i_src_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [16:0] o_vram_addr,
    output logic [15:0] o_vram_data,
    output logic [1:0]  o_byte_enable,
    output logic [21:0] o_rom_addr,
    output logic        o_blit_done,
    output logic [16:0] o_busy_count,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int AW = nlrb_pkg::ADDR_W;

    // Configuration.
    logic [2:0] r_gfx_type;
    logic [7:0] r_flags_a, r_flags_b, r_scroll_y;
    logic       r_flip;
    logic [4:0] r_rom_bank;
    logic [5:0] r_rom_banks;

    // Blit state.
    logic [9:0]    r_cur_x, r_cur_y, n_cur_x, n_cur_y;
    logic [7:0]    r_col_left, r_row_left, r_row_width;
    logic [7:0]    n_col_left, n_row_left, n_row_width;
    logic [AW-1:0] r_src, n_src;
    logic [16:0]   r_count, n_count;
    logic          r_active, n_active;
    logic [1:0]    r_dirs, n_dirs;

    // Table read stage and result pair.
    logic          r_s1_v;
    logic [7:0]    r_s1_byte;
    logic          r_s1_dirx, r_s1_abort, r_s1_done;
    logic [16:0]   r_s1_vaddr, r_s1_count;
    logic [AW-1:0] r_s1_rom;

    logic          r_p_v, r_phase;
    logic [16:0]   r_p_vaddr, r_p_count;
    logic [AW-1:0] r_p_rom;
    logic          r_p_done;
    nlrb_pkg::t_pix r_p_pix, pix;

    nlrb_pkg::t_mode mode;

    logic in_acc, byte_go, s1_adv, pair_free, out_acc;
    logic cur_done, cur_abort;
    logic [AW-1:0] src_cur, bank_base;
    logic [nlrb_pkg::LIM_W-1:0] src_lim;
    logic [7:0] dy;
    logic [8:0] px0;

    logic [7:0] lo_hi, lo_lo, hi_hi, hi_lo;
    logic       tab_we;

    assign o_cfg_ready = 1'b1;
    assign mode        = '{gfx_type: r_gfx_type, flags_a: r_flags_a, flags_b: r_flags_b};

    assign out_acc   = r_p_v && i_ready;
    assign pair_free = !r_p_v || (i_ready && r_phase);
    assign s1_adv    = r_s1_v && pair_free;
    assign o_ready   = !r_s1_v || s1_adv;
    assign in_acc    = i_valid && o_ready;
    assign byte_go   = in_acc && (i_req_type == nlrb_pkg::REQ_BYTE) && r_active;
    assign tab_we    = in_acc && (i_req_type == nlrb_pkg::REQ_TABLE);

    // Colour table split by index bit 4 so that both halves of a lookup
    // pair are read in the same cycle for both nibbles.
    nlrb_ram #(.WIDTH(8), .DEPTH(nlrb_pkg::TAB_HALF)) u_tab_lo (
        .i_clk     (i_clk),
        .i_we      (tab_we && !i_table_index[nlrb_pkg::TAB_AW]),
        .i_waddr   (i_table_index[nlrb_pkg::TAB_AW-1:0]),
        .i_wdata   (~i_table_value),
        .i_re      (byte_go),
        .i_raddr_a (i_src_byte[7:4]),
        .i_raddr_b (i_src_byte[3:0]),
        .o_rdata_a (lo_hi),
        .o_rdata_b (lo_lo)
    );

    nlrb_ram #(.WIDTH(8), .DEPTH(nlrb_pkg::TAB_HALF)) u_tab_hi (
        .i_clk     (i_clk),
        .i_we      (tab_we && i_table_index[nlrb_pkg::TAB_AW]),
        .i_waddr   (i_table_index[nlrb_pkg::TAB_AW-1:0]),
        .i_wdata   (~i_table_value),
        .i_re      (byte_go),
        .i_raddr_a (i_src_byte[7:4]),
        .i_raddr_b (i_src_byte[3:0]),
        .o_rdata_a (hi_hi),
        .o_rdata_b (hi_lo)
    );

    nlrb_colour u_colour (
        .i_mode      (mode),
        .i_byte      (r_s1_byte),
        .i_dir_x     (r_s1_dirx),
        .i_abort     (r_s1_abort),
        .i_lo_hi_nib (lo_hi),
        .i_lo_lo_nib (lo_lo),
        .i_hi_hi_nib (hi_hi),
        .i_hi_lo_nib (hi_lo),
        .o_pix       (pix)
    );

    // Source address wraps to zero once it passes the end of source memory.
    assign src_lim   = nlrb_pkg::LIM_W'(r_rom_banks) << nlrb_pkg::BANK_SHIFT;
    assign src_cur   = (nlrb_pkg::LIM_W'(r_src) >= src_lim) ? '0 : r_src;
    assign bank_base = AW'(r_rom_bank) << nlrb_pkg::BANK_SHIFT;

    assign dy  = (r_cur_y[7:0] + r_scroll_y) ^ {8{r_flip}};
    assign px0 = {r_cur_x[7:0], 1'b0} ^ {9{r_flip}};

    assign cur_abort = (r_gfx_type == nlrb_pkg::GFX_HYBRID16) &&
                       !r_flags_b[nlrb_pkg::MFB_DIRECT] &&
                       !r_flags_a[nlrb_pkg::MFA_ALT];

    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_col_left  = r_col_left;
        n_row_left  = r_row_left;
        n_row_width = r_row_width;
        n_src       = r_src;
        n_count     = r_count;
        n_active    = r_active;
        n_dirs      = r_dirs;
        cur_done    = 1'b0;
        if (in_acc && (i_req_type == nlrb_pkg::REQ_START)) begin
            if ((r_gfx_type == nlrb_pkg::GFX_PURE12) && r_flags_a[nlrb_pkg::MFA_ALT]) begin
                n_active = 1'b0;
            end else begin
                n_count     = '0;
                n_cur_x     = 10'(i_dest_x) + 10'(i_size_x);
                n_cur_y     = 10'(i_dest_y) + 10'(i_size_y);
                n_row_width = i_dir_x ? ~i_size_x : i_size_x;
                n_col_left  = n_row_width;
                n_row_left  = i_dir_y ? ~i_size_y : i_size_y;
                n_dirs      = {i_dir_y, i_dir_x};
                n_src       = bank_base + AW'({i_source_start, 1'b0});
                n_active    = 1'b1;
            end
        end else if (byte_go) begin
            n_src = src_cur + 1'b1;
            if (cur_abort) begin
                n_active = 1'b0;
                cur_done = 1'b1;
            end else begin
                n_count = r_count + 1'b1;
                if (r_col_left != '0) begin
                    n_col_left = r_col_left - 1'b1;
                    n_cur_x    = r_dirs[0] ? r_cur_x + 1'b1 : r_cur_x - 1'b1;
                end else if (r_row_left == '0) begin
                    n_active = 1'b0;
                    cur_done = 1'b1;
                end else begin
                    n_row_left = r_row_left - 1'b1;
                    n_col_left = r_row_width;
                    n_cur_x    = r_dirs[0] ? r_cur_x - 10'(r_row_width)
                                           : r_cur_x + 10'(r_row_width);
                    n_cur_y    = r_dirs[1] ? r_cur_y + 1'b1 : r_cur_y - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gfx_type  <= nlrb_pkg::GFX_8BIT;
            r_flags_a   <= '0;
            r_flags_b   <= '0;
            r_scroll_y  <= '0;
            r_flip      <= 1'b0;
            r_rom_bank  <= '0;
            r_rom_banks <= 6'd1;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_col_left  <= '0;
            r_row_left  <= '0;
            r_row_width <= '0;
            r_src       <= '0;
            r_count     <= '0;
            r_active    <= 1'b0;
            r_dirs      <= '0;
            r_s1_v      <= 1'b0;
            r_p_v       <= 1'b0;
            r_phase     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    nlrb_pkg::CFG_GFX_TYPE:     r_gfx_type  <= i_cfg_data[2:0];
                    nlrb_pkg::CFG_MODE_FLAGS_A: r_flags_a   <= i_cfg_data;
                    nlrb_pkg::CFG_MODE_FLAGS_B: r_flags_b   <= i_cfg_data;
                    nlrb_pkg::CFG_SCROLL_Y:     r_scroll_y  <= i_cfg_data;
                    nlrb_pkg::CFG_FLIP_SCREEN:  r_flip      <= i_cfg_data[0];
                    nlrb_pkg::CFG_ROM_BANK:     r_rom_bank  <= i_cfg_data[4:0];
                    nlrb_pkg::CFG_ROM_BANKS:    r_rom_banks <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_col_left  <= n_col_left;
            r_row_left  <= n_row_left;
            r_row_width <= n_row_width;
            r_src       <= n_src;
            r_count     <= n_count;
            r_active    <= n_active;
            r_dirs      <= n_dirs;
            if (o_ready) begin
                r_s1_v <= byte_go;
            end
            if (pair_free) begin
                r_p_v   <= r_s1_v;
                r_phase <= 1'b0;
            end else if (out_acc) begin
                r_phase <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (byte_go) begin
            r_s1_byte  <= i_src_byte;
            r_s1_dirx  <= r_dirs[0];
            r_s1_abort <= cur_abort;
            r_s1_done  <= cur_done;
            r_s1_vaddr <= {dy, px0};
            r_s1_count <= n_count;
            r_s1_rom   <= src_cur;
        end
        if (s1_adv) begin
            r_p_pix   <= pix;
            r_p_vaddr <= r_s1_vaddr;
            r_p_count <= r_s1_count;
            r_p_rom   <= r_s1_rom;
            r_p_done  <= r_s1_done;
        end
    end

    // The second pixel sits next to the first, flipped or not.
    assign o_valid       = r_p_v;
    assign o_vram_addr   = {r_p_vaddr[16:1], r_p_vaddr[0] ^ r_phase};
    assign o_vram_data   = r_phase ? r_p_pix.data1 : r_p_pix.data0;
    assign o_byte_enable = r_phase ? r_p_pix.be1 : r_p_pix.be0;
    assign o_rom_addr    = r_p_rom;
    assign o_blit_done   = r_p_done;
    assign o_busy_count  = r_p_count;
    assign o_last        = r_phase;

endmodule

/* src/nlrb_ram.sv */
// Generic synchronous RAM: one write port, two read ports with registered data.
// No dependencies.
module nlrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

/* src/nlrb_colour.sv */
// Pixel colour datapath: turns one source byte and its colour table reads into
// two pixel values with byte enables. Depends on nlrb_pkg.
module nlrb_colour (
    input  nlrb_pkg::t_mode i_mode,
    input  logic [7:0]      i_byte,
    input  logic            i_dir_x,
    input  logic            i_abort,
    input  logic [7:0]      i_lo_hi_nib,
    input  logic [7:0]      i_lo_lo_nib,
    input  logic [7:0]      i_hi_hi_nib,
    input  logic [7:0]      i_hi_lo_nib,
    output nlrb_pkg::t_pix  o_pix
);

    logic [7:0]  t1_lo, t1_hi, t2_lo, t2_hi;
    logic [15:0] c1, c2;
    logic [11:0] e1, e2;
    logic [7:0]  h12, cc1, cc2, dsel;
    logic        high;

    // The first pixel takes the low nibble when stepping upward in x.
    assign t1_lo = i_dir_x ? i_lo_lo_nib : i_lo_hi_nib;
    assign t1_hi = i_dir_x ? i_hi_lo_nib : i_hi_hi_nib;
    assign t2_lo = i_dir_x ? i_lo_hi_nib : i_lo_lo_nib;
    assign t2_hi = i_dir_x ? i_hi_hi_nib : i_hi_lo_nib;

    assign c1   = {t1_lo, t1_hi[3:0], 4'h0};
    assign c2   = {t2_lo, t2_hi[3:0], 4'h0};
    assign e1   = {t1_hi[3:0], t1_lo};
    assign e2   = {t2_hi[3:0], t2_lo};
    assign h12  = i_mode.flags_a[nlrb_pkg::MFA_UPPER] ? i_lo_hi_nib : i_lo_lo_nib;
    assign dsel = i_byte;
    assign cc1  = i_mode.flags_a[nlrb_pkg::MFA_DIRECT] ? dsel : t1_lo;
    assign cc2  = i_mode.flags_a[nlrb_pkg::MFA_DIRECT] ? dsel : t2_lo;
    assign high = (i_mode.gfx_type == nlrb_pkg::GFX_PURE16) &&
                  !i_mode.flags_a[nlrb_pkg::MFA_ALT];

    always_comb begin
        o_pix = '0;
        if (i_abort) begin
            o_pix = '0;
        end else if (i_mode.gfx_type == nlrb_pkg::GFX_HYBRID16) begin
            if (i_mode.flags_b[nlrb_pkg::MFB_DIRECT]) begin
                if (i_byte != nlrb_pkg::TRANSP_8) begin
                    if (i_mode.flags_b[nlrb_pkg::MFB_LOW]) begin
                        o_pix.data0 = {8'h00, i_byte};
                        o_pix.be0   = nlrb_pkg::BE_LOW;
                    end else begin
                        o_pix.data0 = {i_byte, 8'h00};
                        o_pix.be0   = nlrb_pkg::BE_HIGH;
                    end
                    o_pix.data1 = o_pix.data0;
                    o_pix.be1   = o_pix.be0;
                end
            end else begin
                // Bits 5 and 4 of the lookup move down to bits 4 and 2.
                if (c1 != nlrb_pkg::TRANSP_16) begin
                    o_pix.data0 = {c1[15:6], 1'b0, c1[5], 1'b0, c1[4], 2'b00};
                    o_pix.be0   = nlrb_pkg::BE_BOTH;
                end
                if (c2 != nlrb_pkg::TRANSP_16) begin
                    o_pix.data1 = {c2[15:6], 1'b0, c2[5], 1'b0, c2[4], 2'b00};
                    o_pix.be1   = nlrb_pkg::BE_BOTH;
                end
            end
        end else if (i_mode.gfx_type == nlrb_pkg::GFX_PURE12) begin
            if (e1 != nlrb_pkg::TRANSP_12) begin
                o_pix.data0 = {4'h0, e1};
                o_pix.be0   = nlrb_pkg::BE_BOTH;
            end
            if (e2 != nlrb_pkg::TRANSP_12) begin
                o_pix.data1 = {4'h0, e2};
                o_pix.be1   = nlrb_pkg::BE_BOTH;
            end
        end else if ((i_mode.gfx_type == nlrb_pkg::GFX_HYBRID12) &&
                     i_mode.flags_a[nlrb_pkg::MFA_ALT]) begin
            if (h12 != nlrb_pkg::TRANSP_8) begin
                o_pix.data0 = {4'h0, h12[3:0], 8'h00};
                o_pix.data1 = o_pix.data0;
                o_pix.be0   = nlrb_pkg::BE_HIGH;
                o_pix.be1   = nlrb_pkg::BE_HIGH;
            end
        end else begin
            if (cc1 != nlrb_pkg::TRANSP_8) begin
                o_pix.data0 = high ? {cc1, 8'h00} : {8'h00, cc1};
                o_pix.be0   = high ? nlrb_pkg::BE_HIGH : nlrb_pkg::BE_LOW;
            end
            if (cc2 != nlrb_pkg::TRANSP_8) begin
                o_pix.data1 = high ? {cc2, 8'h00} : {8'h00, cc2};
                o_pix.be1   = high ? nlrb_pkg::BE_HIGH : nlrb_pkg::BE_LOW;
            end
        end
    end

endmodule
